>>> sv/kappa_sigma_clip_stack_core_macros.svh
// assertion macros for the clipping core
`ifndef KAPPA_SIGMA_CLIP_STACK_CORE_MACROS_SVH
`define KAPPA_SIGMA_CLIP_STACK_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define KSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication checked outside reset
`define KSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> sv/ksc_pkg.sv
`default_nettype none
package ksc_pkg;
    localparam int MaxFramesDef = 64;
    localparam int SampleW = 16;
    localparam int CountW = 7;
    localparam int KappaW = 7;
    localparam int PassW = 5;
    localparam logic [KappaW-1:0] KappaReset = 7'd30;
    localparam logic [PassW-1:0] PassReset = 5'd3;
    localparam logic [0:0] AddrKappa = 1'b0;
    localparam logic [0:0] AddrPass = 1'b1;

    // back part sequencing
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUMW,
        ST_VAR1,
        ST_VAR2,
        ST_CMP,
        ST_CMPW,
        ST_SORT,
        ST_EMIT,
        ST_EMPTY
    } back_state_t;

    // one queued request from the front part
    typedef struct packed {
        logic [SampleW-1:0] sample;
        logic               last;
    } req_t;
endpackage
`default_nettype wire

>>> sv/ksc_front.sv
`default_nettype none
module ksc_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ksc_pkg::req_t   in_req,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output ksc_pkg::req_t        q_req
);
    import ksc_pkg::*;

    // two-entry request queue
    req_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_req;
    end
endmodule
`default_nettype wire

>>> sv/ksc_back.sv
`default_nettype none
module ksc_back #(
    parameter int MAX_FRAMES = ksc_pkg::MaxFramesDef
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ksc_pkg::KappaW-1:0]    kappa,
    input  wire logic [ksc_pkg::PassW-1:0]     passes,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire ksc_pkg::req_t                 q_req,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ksc_pkg::SampleW-1:0]        out_value,
    output logic                               out_last,
    output logic [ksc_pkg::CountW-1:0]         out_count,
    output logic                               out_none
);
    import ksc_pkg::*;

    localparam int IdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    // sample memory, one write port and one registered read port
    logic [SampleW-1:0] store_mem [MAX_FRAMES];
    logic [SampleW-1:0] rd_reg;
    logic [IdxW-1:0]    raddr;
    logic               wen;
    logic [IdxW-1:0]    waddr;
    logic [SampleW-1:0] wdata;

    logic [MAX_FRAMES-1:0] rej_reg, rej_next;
    logic [MAX_FRAMES-1:0] done_reg, done_next;
    logic [CountW-1:0]  ld_reg, ld_next;
    back_state_t        st_reg, st_next;
    logic [IdxW:0]      idx_reg, idx_next;
    logic               rdv_reg, rdv_next;
    logic [IdxW-1:0]    rdi_reg, rdi_next;
    logic [PassW-1:0]   pass_reg, pass_next;
    logic [CountW-1:0]  n_reg, n_next;
    logic [22:0]        s_reg, s_next;
    logic [38:0]        q2_reg, q2_next;
    logic [45:0]        nq_reg, nq_next;
    logic [45:0]        var_reg, var_next;
    logic [13:0]        k2_reg, k2_next;
    logic [59:0]        lim_reg, lim_next;
    logic [CountW-1:0]  kept_reg, kept_next;
    logic [CountW-1:0]  emitted_reg, emitted_next;
    logic [SampleW-1:0] best_reg, best_next;
    logic [IdxW-1:0]    bi_reg, bi_next;
    logic               bf_reg, bf_next;
    logic               ov_reg, ov_next;
    logic [SampleW-1:0] ovv_reg, ovv_next;
    logic               ol_reg, ol_next;
    logic [CountW-1:0]  oc_reg, oc_next;
    logic               on_reg, on_next;
    logic               cv_reg, cv_next;
    logic [IdxW-1:0]    ci_reg, ci_next;
    logic [22:0]        dd_reg, dd_next;

    logic [22:0] nx;
    logic [22:0] dd;
    logic [49:0] dsq;
    logic        oslot;

    assign out_valid = ov_reg;
    assign out_value = ovv_reg;
    assign out_last  = ol_reg;
    assign out_count = oc_reg;
    assign out_none  = on_reg;
    assign oslot     = !ov_reg || out_ready;
    assign q_ready   = (st_reg == ST_IDLE);

    // deviation of the sample just read, scaled by n, then squared from its registered copy
    always_comb
    begin
        nx  = 23'(n_reg) * 23'(rd_reg);
        dd  = (nx >= s_reg) ? nx - s_reg : s_reg - nx;
        dsq = 50'(dd_reg) * 50'(dd_reg);
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (q_valid && q_req.last)
                    st_next = (passes == '0) ? ST_SORT : ST_SUM;
            ST_SUM:
                if (idx_reg[IdxW:0] >= (IdxW+1)'(ld_reg))
                    st_next = ST_SUMW;
            ST_SUMW:  st_next = ST_VAR1;
            ST_VAR1:  st_next = ST_VAR2;
            ST_VAR2:  st_next = (n_reg == '0) ? ((pass_reg <= 5'd1) ? ST_SORT : ST_SUM)
                                              : ST_CMP;
            ST_CMP:
                if (idx_reg[IdxW:0] >= (IdxW+1)'(ld_reg))
                    st_next = ST_CMPW;
            ST_CMPW:  st_next = (pass_reg <= 5'd1) ? ST_SORT : ST_SUM;
            ST_SORT:
                if (idx_reg[IdxW:0] >= (IdxW+1)'(ld_reg) && !rdv_reg)
                    st_next = bf_reg ? ST_EMIT : ((emitted_reg == '0) ? ST_EMPTY : ST_IDLE);
            ST_EMIT:
                if (oslot)
                    st_next = ST_SORT;
            ST_EMPTY:
                if (oslot)
                    st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        rej_next = rej_reg; done_next = done_reg; ld_next = ld_reg;
        idx_next = idx_reg; rdv_next = 1'b0; rdi_next = rdi_reg;
        pass_next = pass_reg; n_next = n_reg; s_next = s_reg; q2_next = q2_reg;
        nq_next = nq_reg; var_next = var_reg; k2_next = k2_reg;
        lim_next = lim_reg; kept_next = kept_reg; emitted_next = emitted_reg;
        best_next = best_reg; bi_next = bi_reg; bf_next = bf_reg;
        ov_next = ov_reg && !out_ready; ovv_next = ovv_reg; ol_next = ol_reg;
        oc_next = oc_reg; on_next = on_reg;
        cv_next = 1'b0; ci_next = ci_reg; dd_next = dd_reg;
        raddr = idx_reg[IdxW-1:0];
        wen = 1'b0; waddr = ld_reg[IdxW-1:0]; wdata = q_req.sample;
        case (st_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (q_valid)
                begin
                    if (ld_reg < CountW'(MAX_FRAMES))
                    begin
                        wen = 1'b1;
                        rej_next[ld_reg[IdxW-1:0]] = 1'b0;
                        ld_next = ld_reg + 1'b1;
                    end
                    if (q_req.last)
                    begin
                        pass_next = passes;
                        n_next = '0; s_next = '0; q2_next = '0;
                        done_next = '0; emitted_next = '0; bf_next = 1'b0;
                        k2_next = 14'(kappa) * 14'(kappa);
                    end
                end
            end
            ST_SUM, ST_CMP, ST_SORT:
            begin
                if (idx_reg[IdxW:0] < (IdxW+1)'(ld_reg))
                begin
                    rdv_next = 1'b1;
                    rdi_next = idx_reg[IdxW-1:0];
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
        // results of reads issued the cycle before
        if (rdv_reg && !rej_reg[rdi_reg])
        begin
            if (st_reg == ST_SUM || st_reg == ST_SUMW)
            begin
                n_next  = n_reg + 1'b1;
                s_next  = s_reg + 23'(rd_reg);
                q2_next = q2_reg + 39'(32'(rd_reg) * 32'(rd_reg));
            end
            else if (st_reg == ST_CMP || st_reg == ST_CMPW)
            begin
                cv_next = 1'b1;
                ci_next = rdi_reg;
                dd_next = dd;
            end
            else if ((st_reg == ST_SORT) && !done_reg[rdi_reg])
            begin
                if (!bf_reg || rd_reg < best_reg)
                begin
                    bf_next = 1'b1; best_next = rd_reg; bi_next = rdi_reg;
                end
                if (emitted_reg == '0)
                    kept_next = kept_reg + 1'b1;
            end
        end
        // clipping decision on the deviation registered the cycle before
        if (cv_reg && (60'(dsq) * 60'd100 > lim_reg))
            rej_next[ci_reg] = 1'b1;
        case (st_reg)
            ST_VAR1:
                nq_next = 46'(n_reg) * 46'(q2_reg);
            ST_VAR2:
            begin
                var_next = nq_reg - 46'(s_reg) * 46'(s_reg);
                idx_next = '0;
                if (n_reg == '0)
                begin
                    pass_next = pass_reg - 1'b1;
                    n_next = '0; s_next = '0; q2_next = '0;
                end
            end
            ST_CMP:
                if (idx_reg == '0 && !rdv_reg)
                    lim_next = 60'(k2_reg) * 60'(var_reg);
            ST_SUMW:
                idx_next = '0;
            ST_CMPW:
            begin
                pass_next = pass_reg - 1'b1;
                n_next = '0; s_next = '0; q2_next = '0;
                idx_next = '0; kept_next = '0;
            end
            ST_EMIT:
                if (oslot)
                begin
                    ov_next = 1'b1; ovv_next = best_reg;
                    emitted_next = emitted_reg + 1'b1;
                    ol_next = (emitted_reg + 1'b1 == kept_reg);
                    oc_next = kept_reg; on_next = 1'b0;
                    done_next[bi_reg] = 1'b1;
                    bf_next = 1'b0; idx_next = '0;
                end
            ST_EMPTY:
                if (oslot)
                begin
                    ov_next = 1'b1; ovv_next = '0; ol_next = 1'b1;
                    oc_next = '0; on_next = 1'b1;
                end
            default: ;
        endcase
        if (st_reg == ST_SORT && st_next == ST_IDLE)
        begin
            ld_next = '0; rej_next = '0;
        end
        if (st_reg == ST_EMPTY && oslot)
        begin
            ld_next = '0; rej_next = '0;
        end
        if (st_reg == ST_IDLE && st_next == ST_SORT)
            kept_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (wen)
            store_mem[waddr] <= wdata;
        rd_reg <= store_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; rej_reg <= '0; ld_reg <= '0; ov_reg <= 1'b0;
            rdv_reg <= 1'b0; idx_reg <= '0; done_reg <= '0; cv_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; rej_reg <= rej_next; ld_reg <= ld_next;
            ov_reg <= ov_next; rdv_reg <= rdv_next; idx_reg <= idx_next;
            done_reg <= done_next; cv_reg <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdi_reg <= rdi_next; pass_reg <= pass_next; n_reg <= n_next;
        s_reg <= s_next; q2_reg <= q2_next; nq_reg <= nq_next;
        var_reg <= var_next; k2_reg <= k2_next; lim_reg <= lim_next;
        kept_reg <= kept_next; emitted_reg <= emitted_next; best_reg <= best_next;
        bi_reg <= bi_next; bf_reg <= bf_next; ovv_reg <= ovv_next;
        ol_reg <= ol_next; oc_reg <= oc_next; on_reg <= on_next;
        ci_reg <= ci_next; dd_reg <= dd_next;
    end
endmodule
`default_nettype wire

>>> sv/kappa_sigma_clip_stack_core.sv
// channel  dir  tdata                         tuser      tlast
// s_axis   in   sample[15:0]                  -          last_sample
// m_axis   out  kept_value[15:0], count[22:16] none_kept  last_kept
// apb      cfg  0x0 kappa_tenths, 0x4 pass_count
// one sample a cycle while loading through a two-entry request queue, which stalls
// while the back part works on a stack; that work is set by the single sample memory
// read port shared by sums, compares and sort
// reset is asynchronous and active low; the store needs no clearing
// each output stalls on its own through the queue and the output register
`default_nettype none
module kappa_sigma_clip_stack_core #(
    parameter int MAX_FRAMES = ksc_pkg::MaxFramesDef
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // sample
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // kept_value, kept_count, zero pad
    output logic             m_axis_tuser,  // none_kept
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ksc_pkg::*;

    logic [KappaW-1:0] kappa_reg;
    logic [PassW-1:0]  pass_reg;
    req_t in_req, q_req;
    logic q_valid, q_ready;
    logic [SampleW-1:0] v;
    logic [CountW-1:0] c;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == AddrPass) ? 32'(pass_reg) : 32'(kappa_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kappa_reg <= KappaReset;
            pass_reg  <= PassReset;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == AddrKappa)
                kappa_reg <= pwdata[KappaW-1:0];
            else
                pass_reg <= pwdata[PassW-1:0];
        end
    end

    assign in_req.sample = s_axis_tdata;
    assign in_req.last   = s_axis_tlast;
    assign m_axis_tdata  = {1'b0, c, v};

    ksc_front u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req,
        .q_valid, .q_ready, .q_req
    );

    ksc_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
        .clk, .rst_n, .kappa(kappa_reg), .passes(pass_reg),
        .q_valid, .q_ready, .q_req,
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_value(v), .out_last(m_axis_tlast), .out_count(c), .out_none(m_axis_tuser)
    );
endmodule
`default_nettype wire

>>> sv/ksc_checker.sv
`default_nettype none
`include "kappa_sigma_clip_stack_core_macros.svh"
module ksc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);
    // an empty result is alone and carries a zero count
    `KSC_ASSERT_IMPL(a_empty_last, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tlast && m_axis_tdata[22:16] == 7'd0)
    // a real result carries a nonzero count
    `KSC_ASSERT_IMPL(a_count_nz, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[22:16] != 7'd0)
    // a stalled result holds
    `KSC_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule
bind kappa_sigma_clip_stack_core ksc_checker u_ksc_checker (.*);
`default_nettype wire

>>> verif/kappa_sigma_clip_stack_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module kappa_sigma_clip_stack_core_test;
    import ksc_pkg::*;

    localparam int NFRAMES = 64;
    localparam int QUIET_LIMIT = 200000;
    localparam logic [2:0] REG_KAPPA = {2'b00, AddrKappa} << 2;
    localparam logic [2:0] REG_PASS = {2'b00, AddrPass} << 2;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
        logic [6:0]  count;
        logic        empty;
    } kept_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;  // sample
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;  // kept_value[15:0], kept_count[22:16], zero pad
    logic        m_axis_tuser;  // none_kept
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kappa_sigma_clip_stack_core dut (.*);

    // predictor state
    logic [6:0]  kappa_q;
    logic [4:0]  passes_q;
    logic [15:0] stack_q[NFRAMES];
    logic        rejected_q[NFRAMES];
    int          depth_q;

    req_t  pending_reqs[$];
    kept_t expected_kept[$];
    int    errors;
    int    sender_idle;
    int    receiver_idle;
    int    quiet_cycles;
    int    stacks_sent;
    int    results_seen;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
        errors++;
    endtask

    // one clipping pass over the unrejected samples, exact integer test
    function automatic void clip_once();
        logic [127:0] n, s, q, var_n2, lim, nx, d;
        n = 0;
        s = 0;
        q = 0;
        for (int i = 0; i < depth_q; i++)
        begin
            if (!rejected_q[i])
            begin
                n += 1;
                s += stack_q[i];
                q += stack_q[i] * stack_q[i];
            end
        end
        if (n == 0)
            return;
        var_n2 = n * q - s * s;
        lim = kappa_q * kappa_q * var_n2;
        for (int i = 0; i < depth_q; i++)
        begin
            if (!rejected_q[i])
            begin
                nx = n * stack_q[i];
                d = (nx >= s) ? nx - s : s - nx;
                if (d * d * 100 > lim)
                    rejected_q[i] = 1'b1;
            end
        end
    endfunction

    // predict the survivors of the stack that this request closes
    function automatic void predict_request(input req_t r);
        logic [15:0] kept[$];
        kept_t e;
        if (depth_q < NFRAMES)
        begin
            stack_q[depth_q] = r.sample;
            rejected_q[depth_q] = 1'b0;
            depth_q++;
        end
        if (!r.last)
            return;
        for (int p = 0; p < passes_q; p++)
            clip_once();
        for (int i = 0; i < depth_q; i++)
            if (!rejected_q[i])
                kept.push_back(stack_q[i]);
        kept.sort();
        if (kept.size() == 0)
        begin
            e = '{value: 16'd0, last: 1'b1, count: 7'd0, empty: 1'b1};
            expected_kept.push_back(e);
        end
        for (int i = 0; i < kept.size(); i++)
        begin
            e.value = kept[i];
            e.last = (i == kept.size() - 1);
            e.count = 7'(kept.size());
            e.empty = 1'b0;
            expected_kept.push_back(e);
        end
        for (int i = 0; i < NFRAMES; i++)
            rejected_q[i] = 1'b0;
        depth_q = 0;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_request(pending_reqs.pop_front());
            if ((!s_axis_tvalid || s_axis_tready) && !(s_axis_tvalid && s_axis_tready
                && pending_reqs.size() == 0))
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_reqs[0].sample;
                    s_axis_tlast <= pending_reqs[0].last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            else if (s_axis_tvalid && s_axis_tready)
                s_axis_tvalid <= 1'b0;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        kept_t got;
        kept_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= receiver_idle);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got = '{value: m_axis_tdata[15:0], last: m_axis_tlast,
                        count: m_axis_tdata[22:16], empty: m_axis_tuser};
                if (expected_kept.size() == 0)
                    report_mismatch("unexpected result value", got.value, -1);
                else
                begin
                    want = expected_kept.pop_front();
                    if (got.empty != want.empty)
                        report_mismatch("none_kept", got.empty, want.empty);
                    if (got.value != want.value)
                        report_mismatch("kept_value", got.value, want.value);
                    if (got.last != want.last)
                        report_mismatch("last_kept", got.last, want.last);
                    if (got.count != want.count)
                        report_mismatch("kept_count", got.count, want.count);
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_KAPPA)
            kappa_q = data[6:0];
        else
            passes_q = data[4:0];
    endtask

    task automatic queue_stack(input logic [15:0] vals[$]);
        req_t r;
        for (int i = 0; i < vals.size(); i++)
        begin
            r.sample = vals[i];
            r.last = (i == vals.size() - 1);
            pending_reqs.push_back(r);
        end
        stacks_sent++;
    endtask

    // random stack: clustered values with some outliers
    task automatic queue_random_stack();
        logic [15:0] vals[$];
        int n, centre, spread;
        n = ($urandom_range(9) == 0) ? $urandom_range(70, 40) : $urandom_range(12, 1);
        centre = $urandom_range(65535);
        spread = 1 << $urandom_range(12);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(7) == 0)
                vals.push_back(16'($urandom_range(65535)));
            else
                vals.push_back(16'(centre + $urandom_range(spread) - spread / 2));
        end
        queue_stack(vals);
    endtask

    // wait for the stimulus and all results, then let the core settle
    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_kept.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] v[$];
        errors = 0;
        stacks_sent = 0;
        results_seen = 0;
        depth_q = 0;
        kappa_q = KappaReset;
        passes_q = PassReset;
        for (int i = 0; i < NFRAMES; i++)
            rejected_q[i] = 1'b0;
        sender_idle = 0;
        receiver_idle = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed stacks at reset settings
        sender_idle = 35;
        receiver_idle = 70;
        v = '{16'd0, 16'hffff};
        queue_stack(v);
        v = '{16'd5};
        queue_stack(v);
        v = '{16'd7, 16'd7, 16'd7};
        queue_stack(v);
        v = '{16'd100, 16'd101, 16'd99, 16'd100, 16'd102, 16'd98, 16'd60000};
        queue_stack(v);
        v = '{16'h5555, 16'haaaa, 16'h0001, 16'h8000};
        queue_stack(v);
        drain();

        // kappa zero rejects everything off the mean; single pass
        apb_write(REG_KAPPA, 32'd0);
        apb_write(REG_PASS, 32'd1);
        v = '{16'd1, 16'd2, 16'd3};
        queue_stack(v);
        v = '{16'd10, 16'd20};
        queue_stack(v);
        drain();

        // over-full stack at the extremes of kappa and passes
        apb_write(REG_KAPPA, 32'd1);
        apb_write(REG_PASS, 32'd20);
        v.delete();
        for (int i = 0; i < 66; i++)
            v.push_back(16'(i * 997));
        queue_stack(v);
        drain();
        apb_write(REG_KAPPA, 32'd100);
        apb_write(REG_PASS, 32'd0);
        queue_stack(v);
        drain();

        // random phases over several settings and idling profiles
        for (int ph = 0; ph < 6; ph++)
        begin
            sender_idle = (ph < 2) ? 35 : (ph < 4) ? 70 : 0;
            receiver_idle = (ph < 2) ? 70 : (ph < 4) ? 35 : 0;
            apb_write(REG_KAPPA, (ph == 5) ? 32'd100 : $urandom_range(100, 1));
            apb_write(REG_PASS, (ph == 0) ? 32'd20 : $urandom_range(20, 1));
            for (int k = 0; k < 3; k++)
                queue_random_stack();
            drain();
        end

        $display("covered %0d stacks and %0d results over kappa and pass settings",
                 stacks_sent, results_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
